// File: rtl/smw_pkg.sv
// Shared constants for the scrolling marquee window: field widths, operation
// codes, register indexes and the reset values of the width and period registers.
// No dependencies.
package smw_pkg;

   localparam int OP_W      = 2;
   localparam int CHAR_W    = 8;
   localparam int INDEX_W   = 8;
   localparam int COLUMN_W  = 6;
   localparam int WIDTH_W   = 7;
   localparam int LENGTH_W  = 9;
   localparam int PERIOD_W  = 16;
   localparam int POS_W     = 9;
   localparam int SPAN_W    = 10;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam int MAX_WIDTH        = 64;
   localparam int RESULT_CAP       = 64;
   localparam int DEFAULT_MAX_TEXT = 256;

   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
   localparam logic [OP_W-1:0] OP_FRAME = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_LENGTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_PERIOD   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_ENABLE = 2'd3;

   localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 7'd64;
   localparam logic [PERIOD_W-1:0] RESET_PERIOD = 16'd100;
   localparam logic [PERIOD_W-1:0] MIN_PERIOD   = 16'd10;
   localparam logic [PERIOD_W-1:0] COUNT_MAX    = 16'hFFFF;
   localparam logic [CHAR_W-1:0]   SPACE_CHAR   = 8'd32;

endpackage

// File: rtl/smw_if.sv
// Request and response channel interfaces for the scrolling marquee window.
// Depends on smw_pkg for the field widths.
interface smw_req_if
   import smw_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [INDEX_W-1:0]  char_index;
   logic [CHAR_W-1:0]   char_value;

   modport source (output valid, op, char_index, char_value, input ready);
   modport sink (input valid, op, char_index, char_value, output ready);
endinterface

interface smw_rsp_if
   import smw_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [CHAR_W-1:0]   frame_char;
   logic [COLUMN_W-1:0] column;
   logic                last;

   modport source (output valid, frame_char, column, last, input ready);
   modport sink (input valid, frame_char, column, last, output ready);
endinterface

// File: rtl/scrolling_marquee_window.sv
// Scrolling text marquee window: text store, scroll position, tick counter.
// Depends on smw_pkg, smw_req_if, smw_rsp_if and smw_rem.
// A write or a tick that does not step is done in the idle state. A step or a frame
// passes through the remainder unit, which reduces the position by the window span;
// a frame then offers its columns in order. Requests wait while the block is busy.
// Reset clears the position and counter and reloads the control registers, not the text.
module scrolling_marquee_window
   import smw_pkg::*;
#(
   parameter int MAX_TEXT = DEFAULT_MAX_TEXT
)(
   input  logic                  clock,
   input  logic                  reset,
   smw_req_if.sink               req_bus,
   smw_rsp_if.source             rsp_bus,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int ADDR_W = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
   localparam int WIDTH_CAP = (MAX_WIDTH < RESULT_CAP) ? MAX_WIDTH : RESULT_CAP;
   localparam int LENGTH_CAP = (MAX_TEXT < 511) ? MAX_TEXT : 511;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_MOD   = 2'd1;
   localparam logic [1:0] S_FRAME = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic                for_frame_ff, for_frame_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [PERIOD_W-1:0] ms_ff, ms_in;
   logic [WIDTH_W-1:0]  width_reg_ff, width_reg_in;
   logic [LENGTH_W-1:0] length_reg_ff, length_reg_in;
   logic [PERIOD_W-1:0] period_reg_ff, period_reg_in;
   logic                enable_reg_ff, enable_reg_in;
   logic [SPAN_W-1:0]   t_ff, t_in;
   logic [COLUMN_W-1:0] col_ff, col_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]   rd_ff;
   logic                is_text_ff;
   logic [COLUMN_W-1:0] rsp_col_ff;
   logic                rsp_last_ff;

   logic [CHAR_W-1:0]   text_store [MAX_TEXT];

   logic [WIDTH_W-1:0]  eff_width;
   logic [LENGTH_W-1:0] eff_length;
   logic [PERIOD_W-1:0] eff_period;
   logic [SPAN_W-1:0]   span;
   logic [PERIOD_W-1:0] ms_inc;
   logic                accept;
   logic                write_hit;
   logic                load_col;
   logic                col_last;
   logic [SPAN_W-1:0]   t_inc;
   logic                rem_start;
   logic [SPAN_W-1:0]   rem_dividend;
   logic                rem_done;
   logic [SPAN_W-1:0]   rem_value;

   always_comb begin
      eff_width = (width_reg_ff == '0) ? WIDTH_W'(1) : width_reg_ff;
      if (eff_width > WIDTH_W'(WIDTH_CAP)) begin
         eff_width = WIDTH_W'(WIDTH_CAP);
      end
      eff_length = (length_reg_ff > LENGTH_W'(LENGTH_CAP)) ? LENGTH_W'(LENGTH_CAP)
                                                           : length_reg_ff;
      eff_period = (period_reg_ff < MIN_PERIOD) ? MIN_PERIOD : period_reg_ff;
   end

   assign span      = {1'b0, eff_length} + {3'b000, eff_width};
   assign ms_inc    = (ms_ff == COUNT_MAX) ? ms_ff : ms_ff + 1'b1;
   assign accept    = req_bus.valid && (state_ff == S_IDLE);
   assign write_hit = accept && (req_bus.op == OP_WRITE)
                      && (32'(req_bus.char_index) < MAX_TEXT);
   assign load_col  = (state_ff == S_FRAME) && (!rsp_valid_ff || rsp_bus.ready);
   assign col_last  = ({1'b0, col_ff} + 1'b1) == eff_width;
   assign t_inc     = t_ff + 1'b1;

   smw_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rem_dividend),
      .divisor   (span),
      .done      (rem_done),
      .remainder (rem_value)
   );

   always_comb begin
      width_reg_in  = width_reg_ff;
      length_reg_in = length_reg_ff;
      period_reg_in = period_reg_ff;
      enable_reg_in = enable_reg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DISPLAY_WIDTH: width_reg_in  = csr_write_data[WIDTH_W-1:0];
            CSR_TEXT_LENGTH:   length_reg_in = csr_write_data[LENGTH_W-1:0];
            CSR_TICK_PERIOD:   period_reg_in = csr_write_data[PERIOD_W-1:0];
            CSR_SCROLL_ENABLE: enable_reg_in = csr_write_data[0];
            default:           width_reg_in  = width_reg_ff;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      for_frame_in = for_frame_ff;
      pos_in       = pos_ff;
      ms_in        = ms_ff;
      t_in         = t_ff;
      col_in       = col_ff;
      rem_start    = 1'b0;
      rem_dividend = {1'b0, pos_ff};
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_bus.op)
                  OP_WRITE: begin
                     if (write_hit) begin
                        pos_in = '0;
                     end
                  end
                  OP_TICK: begin
                     ms_in = ms_inc;
                     if (enable_reg_ff && (ms_inc >= eff_period)) begin
                        ms_in = '0;
                        if (eff_length != '0) begin
                           rem_start    = 1'b1;
                           rem_dividend = {1'b0, pos_ff} + 1'b1;
                           for_frame_in = 1'b0;
                           state_in     = S_MOD;
                        end
                     end
                  end
                  OP_FRAME: begin
                     rem_start    = 1'b1;
                     for_frame_in = 1'b1;
                     state_in     = S_MOD;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_MOD: begin
            if (rem_done) begin
               if (for_frame_ff) begin
                  t_in     = rem_value;
                  col_in   = '0;
                  state_in = S_FRAME;
               end else begin
                  pos_in   = rem_value[POS_W-1:0];
                  state_in = S_IDLE;
               end
            end
         end
         S_FRAME: begin
            if (load_col) begin
               t_in   = (t_inc == span) ? '0 : t_inc;
               col_in = col_ff + 1'b1;
               if (col_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_col) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         for_frame_ff  <= 1'b0;
         pos_ff        <= '0;
         ms_ff         <= '0;
         width_reg_ff  <= RESET_WIDTH;
         length_reg_ff <= '0;
         period_reg_ff <= RESET_PERIOD;
         enable_reg_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         for_frame_ff  <= for_frame_in;
         pos_ff        <= pos_in;
         ms_ff         <= ms_in;
         width_reg_ff  <= width_reg_in;
         length_reg_ff <= length_reg_in;
         period_reg_ff <= period_reg_in;
         enable_reg_ff <= enable_reg_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      t_ff   <= t_in;
      col_ff <= col_in;
   end

   always_ff @(posedge clock) begin
      if (write_hit) begin
         text_store[ADDR_W'(req_bus.char_index)] <= req_bus.char_value;
      end
      if (load_col) begin
         rd_ff       <= text_store[ADDR_W'(t_ff)];
         is_text_ff  <= t_ff < {1'b0, eff_length};
         rsp_col_ff  <= col_ff;
         rsp_last_ff <= col_last;
      end
   end

   assign req_bus.ready      = (state_ff == S_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.frame_char = is_text_ff ? rd_ff : SPACE_CHAR;
   assign rsp_bus.column     = rsp_col_ff;
   assign rsp_bus.last       = rsp_last_ff;

endmodule

// File: rtl/smw_rem.sv
// Iterative remainder unit: one restoring shift-subtract step per cycle.
// Depends on smw_pkg for the operand width.
module smw_rem
   import smw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SPAN_W-1:0] dividend,
   input  logic [SPAN_W-1:0] divisor,
   output logic              done,
   output logic [SPAN_W-1:0] remainder
);

   localparam int CNT_W = $clog2(SPAN_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SPAN_W-1:0] rem_ff, rem_in;
   logic [SPAN_W-1:0] num_ff, num_in;
   logic [SPAN_W-1:0] dsr_ff, dsr_in;
   logic [SPAN_W:0]   trial;
   logic [SPAN_W:0]   diff;

   assign trial = {rem_ff, num_ff[SPAN_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         num_in   = dividend;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[SPAN_W-1:0];
         end else begin
            rem_in = trial[SPAN_W-1:0];
         end
         num_in   = {num_ff[SPAN_W-2:0], 1'b0};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(SPAN_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
